/* rtl/tmbw_pkg.sv */
`timescale 1ns / 1ps
// shared field widths, action codes and register indexes for the tile map walkability block
package tmbw_pkg;

    localparam int ACTION_W   = 1;
    localparam int ROWCOL_W   = 6;
    localparam int VALUE_W    = 14;
    localparam int POS_W      = 12;
    localparam int SIZE_W     = 7;
    localparam int MAP_W      = 7;
    localparam int MARGIN_W   = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [ACTION_W-1:0] ACT_WRITE = 1'b0;
    localparam logic [ACTION_W-1:0] ACT_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_MAP_COLS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_ROWS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MARGIN   = 2'd2;

    localparam logic [MAP_W-1:0]    MAP_COLS_RST = 7'd16;
    localparam logic [MAP_W-1:0]    MAP_ROWS_RST = 7'd16;
    localparam logic [MARGIN_W-1:0] MARGIN_RST   = 5'd0;

endpackage

/* rtl/tile_map_box_walkability.sv */
`timescale 1ns / 1ps
// tile map walkability: blocked-bit store, box-to-tile span setup and tile scan
//
//  channel   dir   beat contents
//  s_*       in    action, tile write fields, query box fields
//  m_*       out   walkable flag, one beat per query
//  cfg_*     in    map_cols, map_rows, margin register writes
//
// a tile write is stored in the map memory on acceptance if its row < MAX_ROWS and column < MAX_COLS
// a query runs multiply, fix and check states, then scans the nx*ny covered tiles one per cycle
// through the single read port of the map memory, then drains; empty or off-map spans skip the scan
// after reset a clearing pass over all MAX_ROWS*MAX_COLS entries zeroes the map before s_ready rises
// a finished query holds in ST_DONE while a result waits on m_ready, and tile writes wait with it
module tile_map_box_walkability #(
    parameter int MAX_COLS  = 64,
    parameter int MAX_ROWS  = 64,
    parameter int TILE_SIZE = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [tmbw_pkg::ACTION_W-1:0]     s_action,
    input  logic [tmbw_pkg::ROWCOL_W-1:0]     s_tile_row,
    input  logic [tmbw_pkg::ROWCOL_W-1:0]     s_tile_col,
    input  logic [tmbw_pkg::VALUE_W-1:0]      s_tile_value,
    input  logic signed [tmbw_pkg::POS_W-1:0] s_query_x,
    input  logic signed [tmbw_pkg::POS_W-1:0] s_query_y,
    input  logic [tmbw_pkg::SIZE_W-1:0]       s_box_w,
    input  logic [tmbw_pkg::SIZE_W-1:0]       s_box_h,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_walkable,

    input  logic                              cfg_we,
    input  logic [tmbw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tmbw_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import tmbw_pkg::*;

    localparam int DEPTH   = MAX_ROWS * MAX_COLS;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COL_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int LIM_W   = 9;
    localparam int WIDE_W  = 17;
    localparam int NUM_W   = POS_W + 1;
    localparam int MAG_W   = POS_W;
    localparam int QW      = MAG_W;
    localparam int RSH     = 24;
    localparam int RECIP   = (1 << RSH) / TILE_SIZE;
    localparam int RECIP_W = $clog2(RECIP + 1);
    localparam int PW      = MAG_W + RECIP_W;
    localparam int TW      = $clog2(TILE_SIZE + 1);
    localparam int FW      = QW + TW;

    localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);
    localparam logic [TW-1:0]      TILE_C  = TW'(TILE_SIZE);

    // span bound slots
    localparam int XL = 0;
    localparam int XH = 1;
    localparam int YL = 2;
    localparam int YH = 3;

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_MUL, ST_FIX, ST_CHECK, ST_SCAN, ST_DRAIN, ST_DONE
    } state_t;

    state_t               state_reg, state_next;
    logic [AW-1:0]        clr_addr_reg, clr_addr_next;
    logic [MAP_W-1:0]     map_cols_reg, map_cols_next;
    logic [MAP_W-1:0]     map_rows_reg, map_rows_next;
    logic [MARGIN_W-1:0]  margin_reg, margin_next;
    logic [MAG_W-1:0]     mag_reg [4];
    logic [MAG_W-1:0]     mag_next [4];
    logic [3:0]           neg_reg, neg_next;
    logic [QW-1:0]        qest_reg [4];
    logic [QW-1:0]        qest_next [4];
    logic [NUM_W-1:0]     qs_reg [4];
    logic [NUM_W-1:0]     qs_next [4];
    logic [COL_W-1:0]     x_start_reg, x_start_next;
    logic [COL_W-1:0]     x_end_reg, x_end_next;
    logic [COL_W-1:0]     x_cnt_reg, x_cnt_next;
    logic [ROW_W-1:0]     y_end_reg, y_end_next;
    logic [ROW_W-1:0]     y_cnt_reg, y_cnt_next;
    logic                 hit_reg, hit_next;
    logic                 rd_pend_reg, rd_pend_next;
    logic                 result_reg, result_next;
    logic                 m_valid_reg, m_valid_next;
    logic                 m_walkable_reg, m_walkable_next;

    logic                 mem [DEPTH];
    logic                 rd_data_reg;
    logic [AW-1:0]        rd_addr;
    logic [AW-1:0]        mem_waddr;
    logic                 mem_wdata;
    logic                 mem_we;

    logic [NUM_W-1:0]     num [4];
    logic [LIM_W-1:0]     cols_eff;
    logic [LIM_W-1:0]     rows_eff;
    logic [WIDE_W-1:0]    scan_wide;
    logic [WIDE_W-1:0]    wr_wide;
    logic                 wr_in_map;
    logic                 s_fire;

    assign s_ready    = (state_reg == ST_IDLE);
    assign s_fire     = s_valid && s_ready;
    assign m_valid    = m_valid_reg;
    assign m_walkable = m_walkable_reg;

    assign cols_eff = ({2'b0, map_cols_reg} > LIM_W'(MAX_COLS)) ? LIM_W'(MAX_COLS)
                                                                : {2'b0, map_cols_reg};
    assign rows_eff = ({2'b0, map_rows_reg} > LIM_W'(MAX_ROWS)) ? LIM_W'(MAX_ROWS)
                                                                : {2'b0, map_rows_reg};

    assign wr_in_map = ({3'b0, s_tile_row} < LIM_W'(MAX_ROWS))
                    && ({3'b0, s_tile_col} < LIM_W'(MAX_COLS));
    assign wr_wide   = WIDE_W'(s_tile_row) * WIDE_W'(MAX_COLS) + WIDE_W'(s_tile_col);
    assign scan_wide = WIDE_W'(y_cnt_reg) * WIDE_W'(MAX_COLS) + WIDE_W'(x_cnt_reg);
    assign rd_addr   = scan_wide[AW-1:0];

    // widened box edges, pixel coordinates before the tile divide
    always_comb begin
        logic [NUM_W-1:0] sx;
        logic [NUM_W-1:0] sy;
        logic [NUM_W-1:0] m13;
        sx  = {s_query_x[POS_W-1], s_query_x};
        sy  = {s_query_y[POS_W-1], s_query_y};
        m13 = NUM_W'(margin_reg);
        num[XL] = sx - m13;
        num[XH] = sx + NUM_W'(s_box_w) + m13 - NUM_W'(1);
        num[YL] = sy - m13;
        num[YH] = sy + NUM_W'(s_box_h) + m13 - NUM_W'(1);
    end

    always_comb begin
        logic [NUM_W-1:0] absn;
        logic [PW-1:0]    prod;
        logic [PW-1:0]    prod_sh;
        logic [FW-1:0]    tq;
        logic [FW-1:0]    rem;
        logic [QW-1:0]    q;
        logic             last_x;
        logic             last_y;

        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        map_cols_next   = map_cols_reg;
        map_rows_next   = map_rows_reg;
        margin_next     = margin_reg;
        neg_next        = neg_reg;
        x_start_next    = x_start_reg;
        x_end_next      = x_end_reg;
        x_cnt_next      = x_cnt_reg;
        y_end_next      = y_end_reg;
        y_cnt_next      = y_cnt_reg;
        hit_next        = hit_reg;
        rd_pend_next    = (state_reg == ST_SCAN);
        result_next     = result_reg;
        m_valid_next    = m_valid_reg;
        m_walkable_next = m_walkable_reg;
        mem_we          = 1'b0;
        mem_waddr       = clr_addr_reg;
        mem_wdata       = 1'b0;
        last_x          = (x_cnt_reg == x_end_reg);
        last_y          = (y_cnt_reg == y_end_reg);
        for (int i = 0; i < 4; i++) begin
            mag_next[i]  = mag_reg[i];
            qest_next[i] = qest_reg[i];
            qs_next[i]   = qs_reg[i];
        end

        if (cfg_we) begin
            case (cfg_index)
                REG_MAP_COLS: map_cols_next = cfg_data[MAP_W-1:0];
                REG_MAP_ROWS: map_rows_next = cfg_data[MAP_W-1:0];
                REG_MARGIN:   margin_next   = cfg_data[MARGIN_W-1:0];
                default:      ;
            endcase
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR: begin
                mem_we        = 1'b1;
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_action == ACT_WRITE) begin
                        mem_we    = wr_in_map;
                        mem_waddr = wr_wide[AW-1:0];
                        mem_wdata = |s_tile_value;
                    end else begin
                        // sign and magnitude so the divide truncates toward zero
                        for (int i = 0; i < 4; i++) begin
                            absn        = num[i][NUM_W-1] ? (~num[i] + NUM_W'(1)) : num[i];
                            neg_next[i] = num[i][NUM_W-1];
                            mag_next[i] = absn[MAG_W-1:0];
                        end
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                // reciprocal estimate, low by at most one
                for (int i = 0; i < 4; i++) begin
                    prod         = {{RECIP_W{1'b0}}, mag_reg[i]} * {{MAG_W{1'b0}}, RECIP_C};
                    prod_sh      = prod >> RSH;
                    qest_next[i] = prod_sh[QW-1:0];
                end
                state_next = ST_FIX;
            end
            ST_FIX: begin
                for (int i = 0; i < 4; i++) begin
                    tq  = {{TW{1'b0}}, qest_reg[i]} * {{QW{1'b0}}, TILE_C};
                    rem = {{TW{1'b0}}, mag_reg[i]} - tq;
                    q   = qest_reg[i] + QW'(rem >= FW'(TILE_SIZE));
                    qs_next[i] = neg_reg[i] ? (~{1'b0, q} + NUM_W'(1)) : {1'b0, q};
                end
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                hit_next     = 1'b0;
                x_start_next = qs_reg[XL][COL_W-1:0];
                x_cnt_next   = qs_reg[XL][COL_W-1:0];
                x_end_next   = qs_reg[XH][COL_W-1:0];
                y_cnt_next   = qs_reg[YL][ROW_W-1:0];
                y_end_next   = qs_reg[YH][ROW_W-1:0];
                if ($signed(qs_reg[XH]) < $signed(qs_reg[XL])
                    || $signed(qs_reg[YH]) < $signed(qs_reg[YL])) begin
                    result_next = 1'b1;
                    state_next  = ST_DONE;
                end else if (qs_reg[XL][NUM_W-1] || qs_reg[YL][NUM_W-1]
                    || $signed(qs_reg[XH]) >= $signed(NUM_W'(cols_eff))
                    || $signed(qs_reg[YH]) >= $signed(NUM_W'(rows_eff))) begin
                    result_next = 1'b0;
                    state_next  = ST_DONE;
                end else begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (rd_pend_reg) begin
                    hit_next = hit_reg | rd_data_reg;
                end
                if (last_x) begin
                    x_cnt_next = x_start_reg;
                    y_cnt_next = y_cnt_reg + ROW_W'(1);
                    if (last_y) begin
                        y_cnt_next = y_cnt_reg;
                        state_next = ST_DRAIN;
                    end
                end else begin
                    x_cnt_next = x_cnt_reg + COL_W'(1);
                end
            end
            ST_DRAIN: begin
                // last tile read lands here
                result_next = !(hit_reg | (rd_pend_reg & rd_data_reg));
                state_next  = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next    = 1'b1;
                    m_walkable_next = result_reg;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            map_cols_reg <= MAP_COLS_RST;
            map_rows_reg <= MAP_ROWS_RST;
            margin_reg   <= MARGIN_RST;
            rd_pend_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            map_cols_reg <= map_cols_next;
            map_rows_reg <= map_rows_next;
            margin_reg   <= margin_next;
            rd_pend_reg  <= rd_pend_next;
            m_valid_reg  <= m_valid_next;
        end
        neg_reg        <= neg_next;
        x_start_reg    <= x_start_next;
        x_end_reg      <= x_end_next;
        x_cnt_reg      <= x_cnt_next;
        y_end_reg      <= y_end_next;
        y_cnt_reg      <= y_cnt_next;
        hit_reg        <= hit_next;
        result_reg     <= result_next;
        m_walkable_reg <= m_walkable_next;
        for (int i = 0; i < 4; i++) begin
            mag_reg[i]  <= mag_next[i];
            qest_reg[i] <= qest_next[i];
            qs_reg[i]   <= qs_next[i];
        end
    end

    // map memory, one write port and one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    a_no_result_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CLEAR |-> !m_valid_reg)
        else $error("result valid during map clearing pass");

    a_scan_in_span: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |-> (x_cnt_reg <= x_end_reg && y_cnt_reg <= y_end_reg))
        else $error("scan counters left the tile span");

    a_drain_has_read: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DRAIN |-> rd_pend_reg)
        else $error("drain without a pending tile read");

    a_done_delivers: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && (!m_valid_reg || m_ready))
        |=> (m_valid_reg && state_reg == ST_IDLE))
        else $error("finished query not moved into the output register");

    a_write_stays_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_action == ACT_WRITE) |=> state_reg == ST_IDLE)
        else $error("tile write started a query");

endmodule
